@@ rtl/tcrw_pkg.sv @@
`timescale 1ns / 1ps

package tcrw_pkg;

    localparam int ADDR_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int SCREEN_W  = COL_W + ROW_W;
    localparam int RING_W    = ADDR_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam int STORE_CELLS        = 1 << ADDR_W;
    localparam int MAX_COLUMNS        = 128;
    localparam int MAX_SCREEN_ROWS    = 64;
    localparam int SCROLLBACK_SCREENS = 8;

    localparam logic [CHAR_W-1:0]    LINE_FEED       = 8'h0A;
    localparam logic                 KIND_WRITE      = 1'b0;
    localparam logic                 KIND_READ       = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 8'd1;
    localparam logic [COL_W-1:0]     COLUMNS_RST     = 8'd80;
    localparam logic [ROW_W-1:0]     ROWS_RST        = 7'd28;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DIVC,
        S_DIVC_WAIT,
        S_STEP,
        S_DIVV,
        S_DIVV_WAIT,
        S_DIST,
        S_SCROLL,
        S_LINE_CHK,
        S_LINE_CLR,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_READ,
        OP_SETUP,
        OP_DIV_COL,
        OP_STEP,
        OP_DIV_VIEW,
        OP_DIST,
        OP_SCROLL,
        OP_LINE_CLR,
        OP_SWEEP,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic kind_read;
        logic eos;
        logic lstart;
        logic div_done;
        logic sweep_last;
        logic lclr_last;
    } t_sts;

endpackage

@@ rtl/tcrw_if.sv @@
`timescale 1ns / 1ps

interface tcrw_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  char_code;
    logic        end_of_string;
    logic [15:0] read_index;

    modport source (output valid, output kind, output char_code, output end_of_string,
                    output read_index, input ready);
    modport sink   (input valid, input kind, input char_code, input end_of_string,
                    input read_index, output ready);
endinterface

interface tcrw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cursor_pos;
    logic [15:0] view_start;
    logic [7:0]  read_data;

    modport source (output valid, output cursor_pos, output view_start, output read_data,
                    input ready);
    modport sink   (input valid, input cursor_pos, input view_start, input read_data,
                    output ready);
endinterface

interface tcrw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/text_console_ring_writer_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// i_in      in         kind, char_code, end_of_string, read_index
// o_out     out        cursor_pos, view_start, read_data
// i_cfg     in         index (0 columns, 1 screen_rows), data
//
// One item at a time. A read fetches the cell and registers it as the result. A write
// takes cursor % columns in the 16-step remainder unit, stores the char unless it is a
// line feed and, on a line start, clears the line; end_of_string adds view % ring and
// a scroll check. Reset (synchronous, active low) clears all 65536 cells of the store;
// i_in is not ready until the clearing pass ends, i_cfg is always ready.
// The output register holds a result until taken; a stalled result holds back only the
// next result, and the next item may be accepted meanwhile.

module text_console_ring_writer_core (
    input logic        i_clk,
    input logic        i_rst_n,
    tcrw_in_if.sink    i_in,
    tcrw_out_if.source o_out,
    tcrw_cfg_if.sink   i_cfg
);
    import tcrw_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    tcrw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tcrw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_kind       (i_in.kind),
        .i_char_code  (i_in.char_code),
        .i_eos        (i_in.end_of_string),
        .i_read_index (i_in.read_index),
        .o_cursor_pos (o_out.cursor_pos),
        .o_view_start (o_out.view_start),
        .o_read_data  (o_out.read_data)
    );

endmodule

@@ rtl/tcrw_div.sv @@
`timescale 1ns / 1ps

module tcrw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcrw_pkg::ADDR_W-1:0] i_dividend,
    input  logic [tcrw_pkg::RING_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [tcrw_pkg::RING_W-1:0] o_rem
);
    import tcrw_pkg::*;

    localparam int DIV_STEPS = ADDR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic [ADDR_W-1:0]   r_num;
    logic [RING_W-1:0]   r_rem;
    logic [RING_W-1:0]   r_den;
    logic [RING_W:0]     w_trial;
    logic [RING_W-1:0]   w_rem_next;

    // One quotient bit per cycle; only the remainder is kept.
    always_comb begin
        w_trial = {r_rem, r_num[ADDR_W-1]};
        if (w_trial >= {1'b0, r_den}) begin
            w_rem_next = RING_W'(w_trial - {1'b0, r_den});
        end else begin
            w_rem_next = w_trial[RING_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[ADDR_W-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/tcrw_dp.sv @@
`timescale 1ns / 1ps

module tcrw_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcrw_pkg::t_cmd                 i_cmd,
    output tcrw_pkg::t_sts                 o_sts,
    input  logic                           i_cfg_we,
    input  logic [tcrw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcrw_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_kind,
    input  logic [tcrw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                           i_eos,
    input  logic [tcrw_pkg::ADDR_W-1:0]    i_read_index,
    output logic [tcrw_pkg::ADDR_W-1:0]    o_cursor_pos,
    output logic [tcrw_pkg::ADDR_W-1:0]    o_view_start,
    output logic [tcrw_pkg::CHAR_W-1:0]    o_read_data
);
    import tcrw_pkg::*;

    logic [CHAR_W-1:0]   r_cells [0:STORE_CELLS-1];

    logic [COL_W-1:0]    r_columns;
    logic [ROW_W-1:0]    r_screen_rows;
    logic [COL_W-1:0]    w_eff_cols;
    logic [ROW_W-1:0]    w_eff_rows;

    logic                r_kind;
    logic [CHAR_W-1:0]   r_char;
    logic                r_eos;
    logic [ADDR_W-1:0]   r_ridx;
    logic [COL_W-1:0]    r_cols;
    logic [ROW_W-1:0]    r_rows;
    logic [SCREEN_W-1:0] r_screen;
    logic [RING_W-1:0]   w_ring;

    logic [ADDR_W-1:0]   r_cursor;
    logic [ADDR_W-1:0]   r_view;
    logic                r_lstart;
    logic [COL_W-1:0]    r_lcnt;
    logic [RING_W-1:0]   r_dist;
    logic [ADDR_W-1:0]   r_sweep;

    logic [CHAR_W-1:0]   r_rdata;
    logic [ADDR_W-1:0]   r_o_cursor;
    logic [ADDR_W-1:0]   r_o_view;
    logic [CHAR_W-1:0]   r_o_data;

    logic                w_div_start;
    logic [ADDR_W-1:0]   w_div_dividend;
    logic [RING_W-1:0]   w_div_divisor;
    logic                w_div_done;
    logic [RING_W-1:0]   w_div_rem;

    logic [COL_W-1:0]    w_rem_col;
    logic [RING_W-1:0]   w_cur_adv;
    logic [ADDR_W-1:0]   w_cur_next;
    logic                w_cur_lstart;
    logic [RING_W:0]     w_dist_sum;
    logic [RING_W-1:0]   w_dist;
    logic [RING_W-1:0]   w_view_adv;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [CHAR_W-1:0]   w_wdata;

    // Out-of-range register values clamp into the supported range.
    always_comb begin
        if (r_columns == '0) begin
            w_eff_cols = COL_W'(1);
        end else if (r_columns > COL_W'(MAX_COLUMNS)) begin
            w_eff_cols = COL_W'(MAX_COLUMNS);
        end else begin
            w_eff_cols = r_columns;
        end
        if (r_screen_rows == '0) begin
            w_eff_rows = ROW_W'(1);
        end else if (r_screen_rows > ROW_W'(MAX_SCREEN_ROWS)) begin
            w_eff_rows = ROW_W'(MAX_SCREEN_ROWS);
        end else begin
            w_eff_rows = r_screen_rows;
        end
    end

    assign w_ring = RING_W'(r_screen * SCROLLBACK_SCREENS);

    tcrw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        w_div_start    = (i_cmd.op == OP_DIV_COL) || (i_cmd.op == OP_DIV_VIEW);
        w_div_dividend = (i_cmd.op == OP_DIV_VIEW) ? r_view : r_cursor;
        w_div_divisor  = (i_cmd.op == OP_DIV_VIEW) ? w_ring : RING_W'(r_cols);
    end

    // Cursor advance. The remainder cursor % columns is in the divider here.
    always_comb begin
        w_rem_col = w_div_rem[COL_W-1:0];
        if (r_char == LINE_FEED) begin
            w_cur_adv    = RING_W'({1'b0, r_cursor} + RING_W'(r_cols) - RING_W'(w_rem_col));
            w_cur_lstart = 1'b1;
        end else begin
            w_cur_adv    = {1'b0, r_cursor} + RING_W'(1);
            w_cur_lstart = ({1'b0, w_rem_col} + (COL_W + 1)'(1)) == {1'b0, r_cols};
        end
        if (w_cur_adv >= w_ring) begin
            w_cur_next   = '0;
            w_cur_lstart = 1'b1;
        end else begin
            w_cur_next = w_cur_adv[ADDR_W-1:0];
        end
    end

    // Ring distance from view start to cursor; the divider holds view % ring.
    always_comb begin
        w_dist_sum = (RING_W + 1)'({2'b00, r_cursor} + {1'b0, w_ring} - {1'b0, w_div_rem});
        if (w_dist_sum >= {1'b0, w_ring}) begin
            w_dist = RING_W'(w_dist_sum - {1'b0, w_ring});
        end else begin
            w_dist = w_dist_sum[RING_W-1:0];
        end
        w_view_adv = {1'b0, r_view} + RING_W'(r_cols);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cursor;
        w_wdata = '0;
        unique case (i_cmd.op)
            OP_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
            end
            OP_STEP: begin
                w_we    = (r_char != LINE_FEED);
                w_wdata = r_char;
            end
            OP_LINE_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_cursor + ADDR_W'(r_lcnt);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_waddr] <= w_wdata;
        end
        if (i_cmd.op == OP_READ) begin
            r_rdata <= r_cells[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns     <= COLUMNS_RST;
            r_screen_rows <= ROWS_RST;
            r_cursor      <= '0;
            r_view        <= '0;
            r_sweep       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_COLUMNS:     r_columns     <= i_cfg_data[COL_W-1:0];
                    REG_SCREEN_ROWS: r_screen_rows <= i_cfg_data[ROW_W-1:0];
                    default:         r_columns     <= r_columns;
                endcase
            end
            unique case (i_cmd.op)
                OP_SWEEP: r_sweep <= r_sweep + ADDR_W'(1);
                OP_STEP:  r_cursor <= w_cur_next;
                OP_SCROLL: begin
                    if (r_dist >= RING_W'(r_screen)) begin
                        r_view <= (w_view_adv >= w_ring) ? '0 : w_view_adv[ADDR_W-1:0];
                    end
                end
                default: r_view <= r_view;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_kind <= i_kind;
                r_char <= i_char_code;
                r_eos  <= i_eos;
                r_ridx <= i_read_index;
                r_cols <= w_eff_cols;
                r_rows <= w_eff_rows;
            end
            OP_SETUP: r_screen <= SCREEN_W'(r_cols * r_rows);
            OP_STEP: begin
                r_lstart <= w_cur_lstart;
                r_lcnt   <= '0;
            end
            OP_DIST:     r_dist <= w_dist;
            OP_LINE_CLR: r_lcnt <= r_lcnt + COL_W'(1);
            OP_FINISH: begin
                r_o_cursor <= r_cursor;
                r_o_view   <= r_view;
                r_o_data   <= (r_kind == KIND_READ) ? r_rdata : '0;
            end
            default: r_lcnt <= r_lcnt;
        endcase
    end

    always_comb begin
        o_sts.kind_read  = (r_kind == KIND_READ);
        o_sts.eos        = r_eos;
        o_sts.lstart     = r_lstart;
        o_sts.div_done   = w_div_done;
        o_sts.sweep_last = (r_sweep == '1);
        o_sts.lclr_last  = (r_lcnt == r_cols - COL_W'(1));
    end

    assign o_cursor_pos = r_o_cursor;
    assign o_view_start = r_o_view;
    assign o_read_data  = r_o_data;

endmodule

@@ rtl/tcrw_ctrl.sv @@
`timescale 1ns / 1ps

module tcrw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tcrw_pkg::t_sts i_sts,
    output tcrw_pkg::t_cmd o_cmd
);
    import tcrw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_SWEEP;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.kind_read) begin
                    o_cmd.op = OP_READ;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = OP_SETUP;
                    n_state  = S_DIVC;
                end
            end
            S_DIVC: begin
                o_cmd.op = OP_DIV_COL;
                n_state  = S_DIVC_WAIT;
            end
            S_DIVC_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = i_sts.eos ? S_DIVV : S_LINE_CHK;
            end
            S_DIVV: begin
                o_cmd.op = OP_DIV_VIEW;
                n_state  = S_DIVV_WAIT;
            end
            S_DIVV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.op = OP_DIST;
                n_state  = S_SCROLL;
            end
            S_SCROLL: begin
                o_cmd.op = OP_SCROLL;
                n_state  = S_LINE_CHK;
            end
            S_LINE_CHK: begin
                n_state = i_sts.lstart ? S_LINE_CLR : S_FINISH;
            end
            S_LINE_CLR: begin
                o_cmd.op = OP_LINE_CLR;
                if (i_sts.lclr_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Wait here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/tcrw_checker.sv @@
`timescale 1ns / 1ps

module tcrw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_cursor_pos,
    input logic [15:0] i_view_start,
    input logic [7:0]  i_read_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cursor_pos)
            && $stable(i_view_start) && $stable(i_read_data))
        else $error("result beat changed while stalled");

    // Items are worked one at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

    // Reset starts the store clearing pass with nothing to deliver.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("block active right after reset");

    // A new result only appears while the block is busy with an item.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while input was ready");

endmodule

bind text_console_ring_writer_core tcrw_checker u_tcrw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cursor_pos (o_out.cursor_pos),
    .i_view_start (o_out.view_start),
    .i_read_data  (o_out.read_data)
);
